/* rtl/core/psfc_pkg.sv */
// Package: format codes and register map for the PCM sample format converter.
`timescale 1ns / 1ps
package psfc_pkg;
  typedef enum logic [3:0] {
    FMT_U8    = 4'd0,
    FMT_I8    = 4'd1,
    FMT_I16LE = 4'd2,
    FMT_I16BE = 4'd3,
    FMT_I24LE = 4'd4,
    FMT_I24BE = 4'd5,
    FMT_I32LE = 4'd6,
    FMT_I32BE = 4'd7,
    FMT_F32   = 4'd8,
    FMT_F64   = 4'd9
  } fmt_t;

  localparam logic [3:0] FMT_RESET = 4'd2;
  localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [7:0] U8_BIAS = 8'd128;
  localparam logic [31:0] FLT_INF = 32'h7F80_0000;
  localparam logic [31:0] FLT_QNAN = 32'h7FC0_0000;

  // Conversion path selected in stage 1
  typedef enum logic [2:0] {
    PATH_NONE = 3'd0,
    PATH_PCM  = 3'd1,
    PATH_INT  = 3'd2,
    PATH_F32  = 3'd3,
    PATH_F64  = 3'd4
  } path_t;
endpackage

/* rtl/core/pcm_sample_format_converter_core.sv */
// Top level: four-stage PCM sample format converter with APB register port.
`timescale 1ns / 1ps
// One sample enters per clock (busy is always low) and its result appears
// with strobe after passing through the four register stages: byte select
// and sign handling, leading-one detect, normalize shift, rounding and
// packing. Results cannot be held off by the receiver; each stands for one
// cycle. source_format (byte address 0, reset i16le) must only be written
// while no sample is in flight.
module pcm_sample_format_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] raw_bytes,
  input  logic        sample_last,
  output logic        strobe,
  output logic signed [15:0] pcm16_value,
  output logic [31:0] float_bits,
  output logic        is_float,
  output logic        result_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psfc_pkg::*;

  logic [3:0] source_format;
  logic       accept;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // Register write and read
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_SOURCE_FORMAT) begin
      source_format <= pwdata[3:0];
    end
  end
  assign prdata = (paddr == REG_SOURCE_FORMAT) ? {28'd0, source_format} : 32'd0;

  // ---------------- Stage 1: byte select, magnitude, double decode
  logic        s1_v, s1_last, s1_sign;
  path_t       s1_path;
  logic [15:0] s1_pcm;
  logic [31:0] s1_mag;      // integer magnitude, or f32 bits
  logic [5:0]  s1_scale;    // 23 or 31
  logic [10:0] s1_dexp;
  logic [51:0] s1_dfrac;

  logic [23:0] c_v24;
  logic [31:0] c_v32;
  always_comb begin
    c_v24 = (source_format == FMT_I24LE) ? raw_bytes[23:0]
          : {raw_bytes[7:0], raw_bytes[15:8], raw_bytes[23:16]};
    c_v32 = (source_format == FMT_I32LE) ? raw_bytes[31:0]
          : {raw_bytes[7:0], raw_bytes[15:8], raw_bytes[23:16], raw_bytes[31:24]};
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= accept;
  end

  always_ff @(posedge clk) begin
    s1_last  <= sample_last;
    s1_pcm   <= 16'd0;
    s1_sign  <= 1'b0;
    s1_mag   <= 32'd0;
    s1_scale <= 6'd23;
    s1_dexp  <= raw_bytes[62:52];
    s1_dfrac <= raw_bytes[51:0];
    unique case (source_format)
      FMT_U8: begin
        s1_path <= PATH_PCM;
        s1_pcm  <= {raw_bytes[7:0] - U8_BIAS, 8'd0};
      end
      FMT_I8: begin
        s1_path <= PATH_PCM;
        s1_pcm  <= {raw_bytes[7:0], 8'd0};
      end
      FMT_I16LE: begin
        s1_path <= PATH_PCM;
        s1_pcm  <= raw_bytes[15:0];
      end
      FMT_I16BE: begin
        s1_path <= PATH_PCM;
        s1_pcm  <= {raw_bytes[7:0], raw_bytes[15:8]};
      end
      FMT_I24LE, FMT_I24BE: begin
        s1_path  <= PATH_INT;
        s1_sign  <= c_v24[23];
        s1_mag   <= c_v24[23] ? {8'd0, 24'd0 - c_v24} : {8'd0, c_v24};
        s1_scale <= 6'd23;
      end
      FMT_I32LE, FMT_I32BE: begin
        s1_path  <= PATH_INT;
        s1_sign  <= c_v32[31];
        s1_mag   <= c_v32[31] ? 32'd0 - c_v32 : c_v32;
        s1_scale <= 6'd31;
      end
      FMT_F32: begin
        s1_path <= PATH_F32;
        s1_mag  <= raw_bytes[31:0];
      end
      FMT_F64: begin
        s1_path <= PATH_F64;
        s1_sign <= raw_bytes[63];
      end
      default: s1_path <= PATH_NONE;
    endcase
  end

  // ---------------- Stage 2: leading-one position, double exponent math
  logic        s2_v, s2_last, s2_sign;
  path_t       s2_path;
  logic [15:0] s2_pcm;
  logic [31:0] s2_mag;
  logic [5:0]  s2_scale;
  logic [4:0]  s2_lz;       // leading zero count of s1_mag
  logic        s2_zero;
  logic [10:0] s2_dexp;
  logic [51:0] s2_dfrac;
  logic signed [12:0] s2_fe;
  logic [5:0]  s2_dsh;      // extra right shift of the mantissa for subnormal results
  logic        s2_dtiny;    // shifts everything out

  logic [4:0] c_lz;
  logic signed [12:0] c_fe;
  always_comb begin
    c_lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (s1_mag[i]) c_lz = 5'(31 - i);
    end
    c_fe = $signed({2'b00, s1_dexp}) - 13'sd896;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else     s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    s2_last  <= s1_last;
    s2_sign  <= s1_sign;
    s2_path  <= s1_path;
    s2_pcm   <= s1_pcm;
    s2_mag   <= s1_mag;
    s2_scale <= s1_scale;
    s2_lz    <= c_lz;
    s2_zero  <= (s1_mag == 32'd0);
    s2_dexp  <= s1_dexp;
    s2_dfrac <= s1_dfrac;
    s2_fe    <= c_fe;
    s2_dtiny <= (c_fe < -13'sd30);
    s2_dsh   <= (c_fe >= 13'sd1) ? 6'd0 : 6'(13'sd1 - c_fe);
  end

  // ---------------- Stage 3: normalize / align shift
  logic        s3_v, s3_last, s3_sign;
  path_t       s3_path;
  logic [15:0] s3_pcm;
  logic [31:0] s3_pass;
  logic        s3_zero;
  logic [23:0] s3_keep;     // 24 kept bits before rounding
  logic        s3_half, s3_sticky;
  logic signed [12:0] s3_exp;
  logic        s3_norm;     // double result normal
  logic        s3_inf, s3_nan, s3_sz;

  logic [31:0] c_nm;
  logic [52:0] c_m;
  logic [115:0] c_al;
  always_comb begin
    c_nm = s2_mag << s2_lz;
    c_m  = {1'b1, s2_dfrac};
    c_al = {c_m, 63'd0} >> s2_dsh;
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else     s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    s3_last <= s2_last;
    s3_sign <= s2_sign;
    s3_path <= s2_path;
    s3_pcm  <= s2_pcm;
    s3_pass <= s2_mag;
    s3_zero <= s2_zero;
    s3_inf  <= 1'b0;
    s3_nan  <= 1'b0;
    s3_sz   <= 1'b0;
    s3_norm <= 1'b1;
    if (s2_path == PATH_F64) begin
      s3_keep   <= c_al[115:92];
      s3_half   <= c_al[91];
      s3_sticky <= |c_al[90:0];
      s3_exp    <= s2_fe;
      s3_norm   <= (s2_fe >= 13'sd1);
      s3_nan    <= (s2_dexp == 11'h7FF) && (s2_dfrac != 52'd0);
      s3_inf    <= ((s2_dexp == 11'h7FF) && (s2_dfrac == 52'd0)) ||
                   ((s2_dexp != 11'h7FF) && (s2_fe >= 13'sd255));
      s3_sz     <= (s2_dexp == 11'd0) || ((s2_fe < 13'sd1) && s2_dtiny);
    end else begin
      s3_keep   <= c_nm[31:8];
      s3_half   <= c_nm[7];
      s3_sticky <= |c_nm[6:0];
      s3_exp    <= 13'sd158 - $signed({8'd0, s2_lz}) - $signed({7'd0, s2_scale});
    end
  end

  // ---------------- Stage 4: round and pack
  logic        s4_v;
  logic [24:0] c_rk;
  logic        c_up;
  logic [12:0] c_e;
  logic [31:0] c_f;
  always_comb begin
    c_up = s3_half && (s3_sticky || s3_keep[0]);
    c_rk = {1'b0, s3_keep} + {24'd0, c_up};
    c_e  = s3_exp;
    if (c_rk[24]) c_e = s3_exp + 13'sd1;
    c_f = 32'd0;
    unique case (s3_path)
      PATH_INT: begin
        if (!s3_zero) c_f = {s3_sign, c_e[7:0], c_rk[24] ? c_rk[23:1] : c_rk[22:0]};
      end
      PATH_F32: c_f = s3_pass;
      PATH_F64: begin
        if (s3_nan)      c_f = {s3_sign, 31'd0} | FLT_QNAN | {9'd0, s3_keep[22:0]};
        else if (s3_inf) c_f = {s3_sign, 31'd0} | FLT_INF;
        else if (s3_sz)  c_f = {s3_sign, 31'd0};
        else if (s3_norm) begin
          if (c_rk[24] && c_e >= 13'sd255) c_f = {s3_sign, 31'd0} | FLT_INF;
          else c_f = {s3_sign, c_e[7:0], c_rk[24] ? c_rk[23:1] : c_rk[22:0]};
        end else c_f = {s3_sign, 31'd0} | {7'd0, c_rk};
      end
      default: c_f = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else     s4_v <= s3_v;
  end

  always_ff @(posedge clk) begin
    result_last <= s3_last;
    pcm16_value <= (s3_path == PATH_PCM) ? s3_pcm : 16'sd0;
    is_float    <= (s3_path == PATH_INT) || (s3_path == PATH_F32) || (s3_path == PATH_F64);
    float_bits  <= c_f;
  end
  assign strobe = s4_v;

  // Every accepted item comes out with strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 strobe) else $error("item lost in pipeline");
  // No result without an accepted item
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept, 4)) else $error("spurious result");
  // A result that is not a float (PCM path) never carries float bits
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_float |-> float_bits == 32'd0) else $error("float bits leak");
endmodule
